// ===== hdl/seasonal_curing_interpolator_assert.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef SEASONAL_CURING_INTERPOLATOR_ASSERT_SVH
`define SEASONAL_CURING_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SCURV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define SCURV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hdl/scurv_pkg.sv =====
package scurv_pkg;

   localparam int unsigned YearBias    = 400;
   localparam int unsigned DayNumWidth = 21;
   localparam int unsigned SeasonDays  = 250;
   localparam logic [13:0] WinterHundredths = 14'd9600;
   localparam logic [8:0]  DaysFieldMax     = 9'd511;

   // Register indexes of the configuration port.
   localparam logic [0:0] CsrGreenupMonth = 1'b0;
   localparam logic [0:0] CsrGreenupDay   = 1'b1;

   // One date handed to a day-number pipeline; year already carries the bias.
   typedef struct packed {
      logic [12:0] year_bias;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_type;

   // Day of year of the first of a month, with March as month zero.
   function automatic logic [8:0] month_offset(input logic [3:0] mp);
      logic [8:0] res;
      case (mp)
         4'd0:    res = 9'd0;
         4'd1:    res = 9'd31;
         4'd2:    res = 9'd61;
         4'd3:    res = 9'd92;
         4'd4:    res = 9'd122;
         4'd5:    res = 9'd153;
         4'd6:    res = 9'd184;
         4'd7:    res = 9'd214;
         4'd8:    res = 9'd245;
         4'd9:    res = 9'd275;
         4'd10:   res = 9'd306;
         4'd11:   res = 9'd337;
         default: res = 9'd0;
      endcase
      return res;
   endfunction

   // Curing table, hundredths of a percent, one entry per 10 days.
   function automatic logic [13:0] cure_base(input logic [4:0] idx);
      logic [13:0] res;
      case (idx)
         5'd0:    res = 14'd9600;
         5'd1:    res = 14'd9500;
         5'd2:    res = 14'd9300;
         5'd3:    res = 14'd9200;
         5'd4:    res = 14'd9050;
         5'd5:    res = 14'd8840;
         5'd6:    res = 14'd8440;
         5'd7:    res = 14'd7810;
         5'd8:    res = 14'd6870;
         5'd9:    res = 14'd5030;
         5'd10:   res = 14'd3290;
         5'd11:   res = 14'd2300;
         5'd12:   res = 14'd2200;
         5'd13:   res = 14'd2100;
         5'd14:   res = 14'd2000;
         5'd15:   res = 14'd2570;
         5'd16:   res = 14'd3500;
         5'd17:   res = 14'd4300;
         5'd18:   res = 14'd4980;
         5'd19:   res = 14'd6000;
         5'd20:   res = 14'd6800;
         5'd21:   res = 14'd7200;
         5'd22:   res = 14'd7500;
         5'd23:   res = 14'd7890;
         5'd24:   res = 14'd8600;
         5'd25:   res = 14'd9600;
         default: res = 14'd9600;
      endcase
      return res;
   endfunction

   // Per-day slope between neighboring table entries (difference over 10, exact).
   function automatic logic signed [8:0] cure_slope(input logic [4:0] idx);
      logic signed [8:0] res;
      case (idx)
         5'd0:    res = -9'sd10;
         5'd1:    res = -9'sd20;
         5'd2:    res = -9'sd10;
         5'd3:    res = -9'sd15;
         5'd4:    res = -9'sd21;
         5'd5:    res = -9'sd40;
         5'd6:    res = -9'sd63;
         5'd7:    res = -9'sd94;
         5'd8:    res = -9'sd184;
         5'd9:    res = -9'sd174;
         5'd10:   res = -9'sd99;
         5'd11:   res = -9'sd10;
         5'd12:   res = -9'sd10;
         5'd13:   res = -9'sd10;
         5'd14:   res = 9'sd57;
         5'd15:   res = 9'sd93;
         5'd16:   res = 9'sd80;
         5'd17:   res = 9'sd68;
         5'd18:   res = 9'sd102;
         5'd19:   res = 9'sd80;
         5'd20:   res = 9'sd40;
         5'd21:   res = 9'sd30;
         5'd22:   res = 9'sd39;
         5'd23:   res = 9'sd71;
         5'd24:   res = 9'sd100;
         default: res = 9'sd0;
      endcase
      return res;
   endfunction

endpackage

// ===== hdl/scurv_daynum.sv =====
// Three-stage day-number pipeline: normalize, scale year, sum.
module scurv_daynum (
   input  logic                clock,
   input  logic                enable,
   input  scurv_pkg::date_type date_in,
   output logic [20:0]         days_out
);

   logic [12:0] year_in, year_ff;
   logic [3:0]  mm;
   logic [3:0]  mp;
   logic [8:0]  doy_in, doy_ff;
   logic [4:0]  day_ff;

   logic [25:0] recip_prod;
   logic [5:0]  cent_in, cent_ff;
   logic [20:0] base_in, base_ff;
   logic [9:0]  off_in, off_ff;

   logic [20:0] days_in, days_ff;

   // Stage 1: fold month underflow and overflow into the year, rotate to a March-based year.
   always_comb begin
      year_in = date_in.year_bias;
      if (date_in.month == 4'd0) begin
         mm      = 4'd11;
         year_in = year_in - 13'd1;
      end else if (date_in.month >= 4'd13) begin
         mm      = date_in.month - 4'd13;
         year_in = year_in + 13'd1;
      end else begin
         mm = date_in.month - 4'd1;
      end
      if (mm < 4'd2) begin
         year_in = year_in - 13'd1;
         mp      = mm + 4'd10;
      end else begin
         mp = mm - 4'd2;
      end
      doy_in = scurv_pkg::month_offset(mp);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         year_ff <= year_in;
         doy_ff  <= doy_in;
         day_ff  <= date_in.day;
      end
   end

   // Stage 2: centuries by reciprocal multiply, days of the whole years.
   always_comb begin
      recip_prod = 26'(year_ff) * 26'd5243;
      cent_in    = recip_prod[24:19];
      base_in    = 21'(year_ff) * 21'd365 + 21'(year_ff >> 2);
      off_in     = 10'(doy_ff) + 10'(day_ff);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cent_ff <= cent_in;
         base_ff <= base_in;
         off_ff  <= off_in;
      end
   end

   // Stage 3: century corrections and day within year.
   assign days_in = base_ff - 21'(cent_ff) + 21'(cent_ff >> 2) + 21'(off_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         days_ff <= days_in;
      end
   end

   assign days_out = days_ff;

endmodule

// ===== hdl/scurv_interp.sv =====
// Three-stage tail: pick the green-up, split the day count, interpolate.
module scurv_interp (
   input  logic        clock,
   input  logic        reset,
   input  logic        enable,
   input  logic        valid_in,
   input  logic [20:0] date_days,
   input  logic [20:0] cur_days,
   input  logic [20:0] prev_days,
   output logic        valid_out,
   output logic [13:0] cured_out,
   output logic [8:0]  days_out
);

   logic [2:0] vld_ff, vld_in;

   logic signed [21:0] d_cur, d_prev, d_sel;
   logic [20:0] d_pos;
   logic [8:0]  sat_in, sat_a_ff, sat_b_ff, sat_c_ff;
   logic        winter_in, winter_a_ff, winter_b_ff;
   logic [7:0]  t_in, t_ff;

   logic [15:0] t_prod;
   logic [4:0]  idx_in, idx_ff;
   logic [3:0]  r_in, r_ff;

   logic signed [14:0] step;
   logic signed [15:0] sum;
   logic [13:0] cured_in, cured_ff;

   assign vld_in = {vld_ff[1:0], valid_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end

   // Stage A: days since this year's green-up, else last year's; clamp, saturate.
   always_comb begin
      d_cur  = $signed({1'b0, date_days}) - $signed({1'b0, cur_days});
      d_prev = $signed({1'b0, date_days}) - $signed({1'b0, prev_days});
      d_sel  = d_cur[21] ? d_prev : d_cur;
      d_pos  = d_sel[21] ? 21'd0 : d_sel[20:0];
      sat_in = (d_pos > 21'(scurv_pkg::DaysFieldMax)) ? scurv_pkg::DaysFieldMax : d_pos[8:0];
      winter_in = (d_pos >= 21'(scurv_pkg::SeasonDays - 1));
      t_in   = 8'(d_pos + 21'd1);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sat_a_ff    <= sat_in;
         winter_a_ff <= winter_in;
         t_ff        <= t_in;
      end
   end

   // Stage B: table index and remainder by reciprocal of ten.
   always_comb begin
      t_prod = 16'(t_ff) * 16'd205;
      idx_in = t_prod[15:11];
      r_in   = 4'(t_ff - 8'(idx_in) * 8'd10);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         idx_ff      <= idx_in;
         r_ff        <= r_in;
         winter_b_ff <= winter_a_ff;
         sat_b_ff    <= sat_a_ff;
      end
   end

   // Stage C: base plus slope times remainder, winter value past the season.
   always_comb begin
      step = 15'(scurv_pkg::cure_slope(idx_ff) * $signed({1'b0, r_ff}));
      sum  = $signed({2'b00, scurv_pkg::cure_base(idx_ff)}) + 16'(step);
      cured_in = winter_b_ff ? scurv_pkg::WinterHundredths : sum[13:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cured_ff <= cured_in;
         sat_c_ff <= sat_b_ff;
      end
   end

   assign valid_out = vld_ff[2];
   assign cured_out = cured_ff;
   assign days_out  = sat_c_ff;

endmodule

// ===== hdl/seasonal_curing_interpolator.sv =====
// Seasonal grass curing from a calendar date.
// Input channel req_*: one date per beat (year, month, day of month in req_tdata).
// Result channel rsp_*: one beat per date, percent cured in hundredths and the
//   whole days since the latest green-up, in the order the dates came in.
// Config channel csr_*: index 0 writes the green-up month, index 1 the green-up
//   day; always ready. Write only while no date is in flight.
// Pipeline: three stages build day numbers for the date and both candidate
//   green-ups, three more select the green-up, split the count and interpolate.
// Throughput: one date per cycle while the output is not stalled; every stage advances together.
// Stall: while rsp_tvalid is high and rsp_tready low, the whole pipeline holds
//   and req_tready drops in the same cycle, so no beat is lost or repeated.
// Reset: clears all valid bits and sets the green-up to January 1.
`include "seasonal_curing_interpolator_assert.svh"

module seasonal_curing_interpolator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [11:0] year, [15:12] month, [20:16] day_of_month
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [13:0] cured_hundredths, [22:14] days_since_greenup
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [4:0]  csr_data
);

   logic [3:0] gm_ff, gm_in;
   logic [4:0] gd_ff, gd_in;

   logic       advance;
   logic [2:0] vld_ff, vld_in;

   logic [11:0] year;
   logic [3:0]  month;
   logic [4:0]  day_of_month;

   scurv_pkg::date_type date_d, cur_d, prev_d;
   logic [20:0] date_days, cur_days, prev_days;

   logic [13:0] cured_hundredths;
   logic [8:0]  days_since_greenup;

   // Configuration registers: always accept a write.
   assign csr_ready = 1'b1;

   always_comb begin
      gm_in = gm_ff;
      gd_in = gd_ff;
      if (csr_valid) begin
         case (csr_index)
            scurv_pkg::CsrGreenupMonth: gm_in = csr_data[3:0];
            scurv_pkg::CsrGreenupDay:   gd_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gm_ff <= 4'd1;
         gd_ff <= 5'd1;
      end else begin
         gm_ff <= gm_in;
         gd_ff <= gd_in;
      end
   end

   // Advance every stage unless a finished beat waits at the output.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   assign year         = req_tdata[11:0];
   assign month        = req_tdata[15:12];
   assign day_of_month = req_tdata[20:16];

   // Date, green-up of the same year, green-up of the year before.
   assign date_d = '{year_bias: 13'(year) + 13'(scurv_pkg::YearBias),
                     month: month, day: day_of_month};
   assign cur_d  = '{year_bias: 13'(year) + 13'(scurv_pkg::YearBias),
                     month: gm_ff, day: gd_ff};
   assign prev_d = '{year_bias: 13'(year) + 13'(scurv_pkg::YearBias - 1),
                     month: gm_ff, day: gd_ff};

   scurv_daynum u_date (
      .clock    (clock),
      .enable   (advance),
      .date_in  (date_d),
      .days_out (date_days)
   );

   scurv_daynum u_cur (
      .clock    (clock),
      .enable   (advance),
      .date_in  (cur_d),
      .days_out (cur_days)
   );

   scurv_daynum u_prev (
      .clock    (clock),
      .enable   (advance),
      .date_in  (prev_d),
      .days_out (prev_days)
   );

   // Valid bits beside the day-number stages.
   assign vld_in = {vld_ff[1:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   scurv_interp u_interp (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .valid_in  (vld_ff[2]),
      .date_days (date_days),
      .cur_days  (cur_days),
      .prev_days (prev_days),
      .valid_out (rsp_tvalid),
      .cured_out (cured_hundredths),
      .days_out  (days_since_greenup)
   );

   assign rsp_tdata = {1'b0, days_since_greenup, cured_hundredths};

   // Past the season the curing value must be the winter value.
   `SCURV_ASSERT_NOW(a_winter_value, clock, reset,
      rsp_tvalid && (days_since_greenup >= 9'd249),
      cured_hundredths == scurv_pkg::WinterHundredths)
   // First day after green-up sits one day into the first table interval.
   `SCURV_ASSERT_NOW(a_first_day, clock, reset,
      rsp_tvalid && (days_since_greenup == 9'd0), cured_hundredths == 14'd9590)
   // Interpolation never leaves the table's range.
   `SCURV_ASSERT_NOW(a_cured_range, clock, reset,
      rsp_tvalid, (cured_hundredths <= 14'd9600) && (cured_hundredths >= 14'd2000))
   // A stalled beat keeps the pipeline frozen, so input is refused meanwhile.
   `SCURV_ASSERT_NOW(a_stall_blocks, clock, reset,
      rsp_tvalid && !rsp_tready, !req_tready)

endmodule

// ===== sim/tb_top.sv =====
module tb_top;

   // Calendar date as carried on the request stream, lowest field last.
   typedef struct packed {
      logic [4:0]  mday;
      logic [3:0]  month;
      logic [11:0] year;
   } cal_date_type;

   // Curing result as carried on the response stream, lowest field last.
   typedef struct packed {
      logic [8:0]  days;
      logic [13:0] cured;
   } cure_type;

   localparam int GrowingDays  = 250;
   localparam int DaysSaturate = 511;
   localparam int RandomDates  = 147;   // per phase, eight phases
   localparam int ReportLimit  = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = scurv_pkg::CsrGreenupMonth;
   logic [4:0]  csr_data = '0;

   // Curing curve in hundredths of a percent, one point every 10 days.
   int curing_curve [26] = '{
      9600, 9500, 9300, 9200, 9050, 8840, 8440, 7810, 6870, 5030,
      3290, 2300, 2200, 2100, 2000, 2570, 3500, 4300, 4980, 6000,
      6800, 7200, 7500, 7890, 8600, 9600
   };

   // Green-up date as the block should hold it; tracks every csr write.
   logic [3:0] gu_month = 4'd1;
   logic [4:0] gu_day = 5'd1;

   cal_date_type pending_dates [$];   // dates waiting for the request driver
   cure_type     expected_cures [$];  // predictions for accepted dates, oldest first
   cal_date_type held_date;
   bit           req_busy = 1'b0;
   int           req_gap = 0;
   int           req_quiet = 0;
   int           rsp_hold = 0;
   int           rsp_quiet = 0;
   int           error_count = 0;

   seasonal_curing_interpolator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [11:0] year, [15:12] month, [20:16] day_of_month
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [13:0] cured_hundredths, [22:14] days_since_greenup
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 0;
   end

   // Serial day of a proleptic Gregorian date. Month 0 and months 13..15 wrap into
   // the neighboring year, day 0 and days past the month end roll over. The
   // year is biased by 400 so everything stays positive; only differences matter.
   function automatic longint serial_day(longint y, longint m, longint d);
      longint mm, era, yoe, mp, doy;
      mm = m - 1;
      if (mm < 0) begin
         mm += 12;
         y -= 1;
      end else if (mm >= 12) begin
         mm -= 12;
         y += 1;
      end
      y += 400;
      // Count from March so the leap day lands at the end of the year.
      if (mm < 2) y -= 1;
      era = y / 400;
      yoe = y - era * 400;
      mp  = (mm + 10) % 12;
      doy = (153 * mp + 2) / 5;
      return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy + d - 1;
   endfunction

   // Days since the latest green-up and the interpolated curing percentage.
   function automatic cure_type predict_cure(cal_date_type dt, logic [3:0] gm,
                                             logic [4:0] gd);
      longint   date_num, span, t, lo, hi;
      cure_type res;
      date_num = serial_day(dt.year, dt.month, dt.mday);
      span = date_num - serial_day(dt.year, gm, gd);
      // Before this year's green-up: count from last year's instead.
      if (span < 0) span = date_num - serial_day(longint'(dt.year) - 1, gm, gd);
      // Still before it (only with wrapped fields): clamp to zero.
      if (span < 0) span = 0;
      t = span + 1;
      if (t < GrowingDays) begin
         lo = curing_curve[t / 10];
         hi = curing_curve[t / 10 + 1];
         res.cured = 14'(lo + ((hi - lo) * (t % 10)) / 10);
      end else begin
         res.cured = 14'd9600;
      end
      res.days = (span > DaysSaturate) ? 9'(DaysSaturate) : span[8:0];
      return res;
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int draw_idle();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mostly well-formed dates, with a share of wrapped months, day 0 and
   // day overflow; century years now and then to hit the leap rule.
   function automatic cal_date_type random_date();
      cal_date_type d;
      int unsigned  pick;
      int unsigned  last;
      bit           leap;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         d.year  = 12'($urandom_range(0, 4095));
         d.month = 4'($urandom_range(0, 15));
         d.mday  = 5'($urandom_range(0, 31));
      end else begin
         if (pick < 16) d.year = 12'($urandom_range(0, 40) * 100);
         else d.year = 12'($urandom_range(1, 4095));
         d.month = 4'($urandom_range(1, 12));
         leap = (d.year % 4 == 0) && ((d.year % 100 != 0) || (d.year % 400 == 0));
         if (d.month == 2) last = leap ? 29 : 28;
         else if (d.month == 4 || d.month == 6 || d.month == 9 || d.month == 11) last = 30;
         else last = 31;
         d.mday = 5'($urandom_range(1, last));
      end
      return d;
   endfunction

   task automatic queue_date(int y, int m, int d);
      cal_date_type dt;
      dt.year  = 12'(y);
      dt.month = 4'(m);
      dt.mday  = 5'(d);
      pending_dates.push_back(dt);
   endtask

   task automatic flag_error(string what, int want, int got);
      if (error_count < ReportLimit)
         $display("mismatch %s: expected %0d, got %0d", what, want, got);
      error_count++;
   endtask

   // Write one csr register and mirror it into the predictor once accepted.
   task automatic write_csr(logic [0:0] idx, logic [4:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == scurv_pkg::CsrGreenupMonth) gu_month = val[3:0];
      else gu_day = val;
      csr_valid <= 1'b0;
   endtask

   // Hold until every queued date has gone in and every result has come back.
   task automatic drain();
      while (pending_dates.size() != 0 || req_busy || expected_cures.size() != 0)
         @(negedge clock);
   endtask

   // Request driver: present one date at a time, record the prediction on the
   // accepting edge, then wait out a random gap before the next beat.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_busy = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_cures.push_back(predict_cure(held_date, gu_month, gu_day));
            req_busy = 1'b0;
         end
         if (!req_busy) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (pending_dates.size() > 0) begin
               held_date = pending_dates.pop_front();
               req_tdata <= {3'b000, held_date.mday, held_date.month, held_date.year};
               req_busy = 1'b1;
               // Draw the gap ahead of the next beat; now and then a gap-free run.
               if (req_quiet > 0) begin
                  req_quiet--;
                  req_gap = 0;
               end else if ($urandom_range(0, 59) == 0) begin
                  req_quiet = $urandom_range(30, 150);
                  req_gap = 0;
               end else begin
                  req_gap = draw_idle();
               end
            end
         end
         // One assignment per edge, so a held valid never dips.
         req_tvalid <= req_busy;
      end
   end

   // Response monitor: check each beat against the oldest prediction and
   // throttle tready with random stalls and stall-free stretches.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_cures.size() == 0) begin
               flag_error("unexpected result beat, cured", -1, rsp_tdata[13:0]);
            end else begin
               cure_type want;
               want = expected_cures.pop_front();
               if (rsp_tdata[13:0] !== want.cured)
                  flag_error("cured_hundredths", want.cured, rsp_tdata[13:0]);
               if (rsp_tdata[22:14] !== want.days)
                  flag_error("days_since_greenup", want.days, rsp_tdata[22:14]);
            end
         end
         if (rsp_quiet > 0) begin
            rsp_quiet--;
            rsp_tready <= 1'b1;
         end else if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            if ($urandom_range(0, 49) == 0) rsp_quiet = $urandom_range(30, 150);
            else if ($urandom_range(0, 3) == 0) rsp_hold = draw_idle();
            rsp_tready <= 1'b1;
         end
      end
   end

   // Stimulus: directed dates under the reset green-up, then one phase per
   // green-up setting, extremes and wrapped values included.
   initial begin
      logic [3:0] phase_month [8];
      logic [4:0] phase_day [8];
      phase_month = '{4'd1, 4'd12, 4'd3, 4'd2, 4'd7, 4'd0, 4'd15, 4'd1};
      phase_day   = '{5'd1, 5'd31, 5'd15, 5'd29, 5'd0, 5'd20, 5'd31, 5'd1};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Field extremes, leap rules, table points and the season boundary.
      queue_date(0, 1, 1);
      queue_date(4095, 12, 31);
      queue_date(1, 1, 1);
      queue_date(2000, 2, 29);      // leap century
      queue_date(1900, 2, 29);      // no leap day, rolls to March 1
      queue_date(2024, 12, 31);     // longest count in a leap year
      queue_date(2023, 4, 10);      // lands on a table point
      queue_date(2023, 9, 5);
      queue_date(2023, 9, 6);       // last day inside the curing season
      queue_date(2023, 9, 7);       // first winter day
      queue_date(2023, 1, 0);       // day zero, last of December before
      queue_date(2023, 2, 31);      // past month end
      queue_date(2023, 0, 15);      // month zero, December of the year before
      queue_date(2023, 13, 0);
      queue_date(2023, 15, 31);     // wraps into March of the next year
      queue_date(0, 0, 0);
      queue_date(4095, 15, 31);
      queue_date(2048, 6, 16);
      queue_date(1365, 10, 21);

      for (int p = 0; p < 8; p++) begin
         if (p > 0) begin
            drain();
            write_csr(scurv_pkg::CsrGreenupMonth, {1'b0, phase_month[p]});
            write_csr(scurv_pkg::CsrGreenupDay, phase_day[p]);
            @(negedge clock);
         end
         if (p == 1) begin
            // Green-up on December 31: a date in the wrapped December before
            // still falls ahead of last year's green-up, so the count clamps.
            queue_date(2023, 0, 1);
            queue_date(2023, 12, 31);
            queue_date(2023, 12, 30);
            queue_date(0, 1, 1);
         end
         for (int i = 0; i < RandomDates; i++)
            pending_dates.push_back(random_date());
      end

      drain();
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_cures.size() == 0) begin
         $display("PASS seasonal_curing_interpolator");
      end else begin
         $display("FAIL seasonal_curing_interpolator");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #8000000;
      $display("FAIL seasonal_curing_interpolator");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/scurv_pkg.sv
hdl/scurv_daynum.sv
hdl/scurv_interp.sv
hdl/seasonal_curing_interpolator.sv
sim/tb_top.sv
